>>> rtl/lr4x_pkg.sv
`default_nettype none
package lr4x_pkg;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] sample;
    } lr4x_in_t;

    typedef struct packed {
        logic signed [15:0] left_value;
        logic signed [15:0] right_value;
    } lr4x_out_t;

    localparam logic [1:0] MODE_AUDIO = 2'd0;
    localparam logic [1:0] MODE_DIAG  = 2'd1;
    localparam logic [1:0] MODE_LED   = 2'd2;

    localparam logic [2:0] REG_BYPASS   = 3'd0;
    localparam logic [2:0] REG_SUB_R    = 3'd1;
    localparam logic [2:0] REG_LP_B0    = 3'd2;
    localparam logic [2:0] REG_HP_B0    = 3'd3;
    localparam logic [2:0] REG_A1       = 3'd4;
    localparam logic [2:0] REG_A2       = 3'd5;
    localparam logic [2:0] REG_SUB_GAIN = 3'd6;
    localparam logic [2:0] REG_WIDE_GAIN = 3'd7;

    localparam int NUM_REGS = 8;

    // datapath micro-operations
    typedef enum logic [3:0] {
        OP_LOAD_X,   // x <- sample*2^24, pick branch coefficient
        OP_Y,        // y <- sat(rnd(b0*x) + z1)
        OP_N1,       // z1 <- sat(rnd(b1*x) - rnd(a1*y) + z2)
        OP_N2,       // z2 <- sat(rnd(b0*x) - rnd(a2*y)), x <- y
        OP_GAIN,     // branch result <- sat16(rnd(y*gain))
        OP_NONE
    } lr4x_op_t;

    typedef struct packed {
        lr4x_op_t   op;
        logic [1:0] stage;    // biquad index 0..3 (lp1, lp2, hp1, hp2)
        logic       branch;   // 0 lowpass, 1 highpass
        logic       clear_z;
        logic       phase;    // 0 low operand half, 1 high half and commit
    } lr4x_cmd_t;

    typedef struct packed {
        logic busy;
    } lr4x_sts_t;

endpackage
`default_nettype wire

>>> rtl/lr4x_datapath.sv
`default_nettype none
module lr4x_datapath #(
    parameter int COEF_FRAC_BITS = 28
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  lr4x_pkg::lr4x_cmd_t       cmd,
    input  wire logic signed [15:0]   sample,
    input  wire logic signed [31:0]   lp_b0,
    input  wire logic signed [31:0]   hp_b0,
    input  wire logic signed [31:0]   a1,
    input  wire logic signed [31:0]   a2,
    input  wire logic [23:0]          sub_gain,
    input  wire logic [23:0]          wide_gain,
    output logic signed [15:0]        sub_out,
    output logic signed [15:0]        wide_out
);
    import lr4x_pkg::*;

    localparam logic signed [47:0] S48_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] S48_MIN = {1'b1, {47{1'b0}}};
    localparam logic signed [87:0] RND_C = 88'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [87:0] RND_G = 88'sd1 <<< 39;

    logic signed [47:0] z_reg [8];
    logic signed [47:0] x_reg;
    logic signed [47:0] y_reg;
    logic signed [15:0] sub_reg;
    logic signed [15:0] wide_reg;
    logic signed [58:0] plo_reg;
    logic signed [56:0] p2lo_reg;

    logic signed [33:0] b0_c;
    logic signed [33:0] b1_c;
    logic signed [33:0] mul_c;
    logic signed [31:0] fb_c;
    logic signed [47:0] mul_v;
    logic signed [24:0] v_lo;
    logic signed [23:0] v_hi;
    logic signed [24:0] y_lo;
    logic signed [23:0] y_hi;
    logic signed [58:0] plo;
    logic signed [58:0] phi;
    logic signed [56:0] p2lo;
    logic signed [56:0] p2hi;
    logic signed [87:0] prod;
    logic signed [87:0] prod2;
    logic signed [55:0] r1;
    logic signed [55:0] r2;
    logic signed [55:0] sum;
    logic signed [47:0] sat_sum;
    logic signed [49:0] g_r;
    logic signed [15:0] g_sat;
    logic [2:0]         zi;

    assign zi = {cmd.stage, 1'b0};

    // select the branch coefficients
    always_comb begin
        b0_c = cmd.branch ? 34'(hp_b0) : 34'(lp_b0);
        b1_c = cmd.branch ? -(34'(hp_b0) <<< 1) : (34'(lp_b0) <<< 1);
    end

    // products split into low and high operand halves, low half first
    always_comb begin
        mul_v = x_reg;
        case (cmd.op)
            OP_N1:   mul_c = b1_c;
            OP_GAIN: begin
                mul_c = cmd.branch ? 34'($signed({1'b0, wide_gain}))
                                   : 34'($signed({1'b0, sub_gain}));
                mul_v = y_reg;
            end
            default: mul_c = b0_c;
        endcase
        fb_c = (cmd.op == OP_N1) ? a1 : a2;
        v_lo = $signed({1'b0, mul_v[23:0]});
        v_hi = mul_v[47:24];
        y_lo = $signed({1'b0, y_reg[23:0]});
        y_hi = y_reg[47:24];
        plo  = 59'(v_lo) * 59'(mul_c);
        phi  = 59'(v_hi) * 59'(mul_c);
        p2lo = 57'(y_lo) * 57'(fb_c);
        p2hi = 57'(y_hi) * 57'(fb_c);
        prod  = (88'(phi) <<< 24) + 88'(plo_reg);
        prod2 = (88'(p2hi) <<< 24) + 88'(p2lo_reg);
        r1 = 56'((prod + RND_C) >>> COEF_FRAC_BITS);
        r2 = 56'((prod2 + RND_C) >>> COEF_FRAC_BITS);
        g_r = 50'((prod + RND_G) >>> 40);
    end

    // combine and saturate to 48 bits; saturate the gain result to 16 bits
    always_comb begin
        case (cmd.op)
            OP_Y:    sum = r1 + 56'(z_reg[zi]);
            OP_N1:   sum = r1 - r2 + 56'(z_reg[zi + 3'd1]);
            OP_N2:   sum = r1 - r2;
            default: sum = '0;
        endcase
        if (sum > 56'(S48_MAX))      sat_sum = S48_MAX;
        else if (sum < 56'(S48_MIN)) sat_sum = S48_MIN;
        else                         sat_sum = sum[47:0];
        if (g_r > 50'sd32767)        g_sat = 16'sh7fff;
        else if (g_r < -50'sd32768)  g_sat = 16'sh8000;
        else                         g_sat = g_r[15:0];
    end

    // hold the low-half partial products
    always_ff @(posedge aclk) begin
        if (!cmd.phase) begin
            plo_reg  <= plo;
            p2lo_reg <= p2lo;
        end
    end

    // filter memory
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_z) begin
            for (int i = 0; i < 8; i++) z_reg[i] <= '0;
        end else if (cmd.phase) begin
            case (cmd.op)
                OP_N1:   z_reg[zi] <= sat_sum;
                OP_N2:   z_reg[zi + 3'd1] <= sat_sum;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.phase) begin
            case (cmd.op)
                OP_LOAD_X: x_reg <= {{8{sample[15]}}, sample, 24'd0};
                OP_Y:      y_reg <= sat_sum;
                OP_N2:     x_reg <= y_reg;
                OP_GAIN: begin
                    if (cmd.branch) wide_reg <= g_sat;
                    else            sub_reg  <= g_sat;
                end
                default: ;
            endcase
        end
    end

    assign sub_out  = sub_reg;
    assign wide_out = wide_reg;
endmodule
`default_nettype wire

>>> rtl/lr4x_ctrl.sv
`default_nettype none
module lr4x_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic            clear_z,
    output lr4x_pkg::lr4x_cmd_t  cmd,
    output lr4x_pkg::lr4x_sts_t  sts,
    output logic                 done
);
    import lr4x_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;

    // sequence: per branch, load x, then 3 ops per stage for two stages, then gain;
    // each op runs its low operand half first, then its high half
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        done       = 1'b0;
        cmd.op      = OP_NONE;
        cmd.branch  = step_reg[4];
        cmd.stage   = {step_reg[4], 1'b0};
        cmd.clear_z = clear_z;
        cmd.phase   = step_reg[0];
        case (step_reg[3:1])
            3'd0: cmd.op = OP_LOAD_X;
            3'd1: cmd.op = OP_Y;
            3'd2: cmd.op = OP_N1;
            3'd3: cmd.op = OP_N2;
            3'd4: begin cmd.op = OP_Y;  cmd.stage[0] = 1'b1; end
            3'd5: begin cmd.op = OP_N1; cmd.stage[0] = 1'b1; end
            3'd6: begin cmd.op = OP_N2; cmd.stage[0] = 1'b1; end
            default: cmd.op = OP_GAIN;
        endcase
        case (state_reg)
            ST_IDLE: begin
                cmd.op = OP_NONE;
                step_next = '0;
                if (start) state_next = ST_RUN;
            end
            ST_RUN: begin
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31) state_next = ST_DONE;
            end
            ST_DONE: begin
                cmd.op = OP_NONE;
                done = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign sts.busy = (state_reg != ST_IDLE);
endmodule
`default_nettype wire

>>> rtl/lr4_crossover_with_peak_meters_unit.sv
`default_nettype none
// Linkwitz-Riley 4th-order crossover with two pairs of peak meters.
// Input channel s_*: one word carries mode and a mono sample. Mode audio
// filters the sample (or passes it in bypass) and returns left/right samples;
// mode diag or LED returns that peak pair and clears it; mode 3 returns zeros.
// Result channel m_*: one word with left and right values, held in an output
// register until taken. A stalled receiver holds the word; the next input
// is accepted once no filter run is busy and the word slot is free or being
// drained. Filtered audio uses one shared multiply datapath that walks 8
// micro-steps per branch (load, three per biquad, gain), each step with every
// product split into operand halves, low half first. A filtered word is
// accepted only after the previous one is done. Bypass and take requests
// can follow back to back. Config channel cfg_*: index 0..7 and data, to be
// written while idle by the user; the block does not enforce it. Any valid
// write clears the filter memory. Reset restores bypass on, routing lowpass
// left, zero coefficients, unity gains, cleared filter memory and peaks.
module lr4_crossover_with_peak_meters_unit #(
    parameter int COEF_FRAC_BITS = 28
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  lr4x_pkg::lr4x_in_t    s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output lr4x_pkg::lr4x_out_t   m_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [31:0]      cfg_data
);
    import lr4x_pkg::*;

    logic               bypass_reg, sub_r_reg;
    logic signed [31:0] lp_b0_reg, hp_b0_reg, a1_reg, a2_reg;
    logic [23:0]        sub_gain_reg, wide_gain_reg;
    logic [14:0]        dl_reg, dr_reg, ll_reg, lr_reg;
    logic               m_valid_reg;
    lr4x_out_t          m_data_reg;
    logic signed [15:0] samp_reg;

    lr4x_cmd_t cmd;
    lr4x_sts_t sts;
    logic      done, start, accept, cfg_acc, load_word;
    logic signed [15:0] sub_out, wide_out;
    logic signed [15:0] lv, rv;
    logic [14:0] al, ar;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid;
    assign s_ready   = !sts.busy && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign start     = accept && s_data.mode == MODE_AUDIO && !bypass_reg;
    assign load_word = done || (accept && !start);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    lr4x_ctrl u_ctrl (
        .aclk, .aresetn, .start, .clear_z(cfg_acc), .cmd, .sts, .done
    );

    lr4x_datapath #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_dp (
        .aclk, .aresetn, .cmd, .sample(samp_reg),
        .lp_b0(lp_b0_reg), .hp_b0(hp_b0_reg), .a1(a1_reg), .a2(a2_reg),
        .sub_gain(sub_gain_reg), .wide_gain(wide_gain_reg),
        .sub_out, .wide_out
    );

    // route audio result or bypassed sample and take its magnitude
    always_comb begin
        if (done) begin
            lv = sub_r_reg ? wide_out : sub_out;
            rv = sub_r_reg ? sub_out : wide_out;
        end else begin
            lv = s_data.sample;
            rv = s_data.sample;
        end
        al = lv[15] ? ((lv == 16'sh8000) ? 15'h7fff : 15'(-lv)) : lv[14:0];
        ar = rv[15] ? ((rv == 16'sh8000) ? 15'h7fff : 15'(-rv)) : rv[14:0];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg    <= 1'b1;
            sub_r_reg     <= 1'b0;
            lp_b0_reg     <= '0;
            hp_b0_reg     <= '0;
            a1_reg        <= '0;
            a2_reg        <= '0;
            sub_gain_reg  <= 24'd65536;
            wide_gain_reg <= 24'd65536;
        end else if (cfg_acc) begin
            case (cfg_index)
                REG_BYPASS:    bypass_reg    <= cfg_data[0];
                REG_SUB_R:     sub_r_reg     <= cfg_data[0];
                REG_LP_B0:     lp_b0_reg     <= cfg_data;
                REG_HP_B0:     hp_b0_reg     <= cfg_data;
                REG_A1:        a1_reg        <= cfg_data;
                REG_A2:        a2_reg        <= cfg_data;
                REG_SUB_GAIN:  sub_gain_reg  <= cfg_data[23:0];
                REG_WIDE_GAIN: wide_gain_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // hold sample for the datapath
    always_ff @(posedge aclk) begin
        if (accept) samp_reg <= s_data.sample;
    end

    // peaks and output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dl_reg <= '0; dr_reg <= '0; ll_reg <= '0; lr_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_word)                   m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (done || (accept && s_data.mode == MODE_AUDIO && bypass_reg)) begin
                m_data_reg  <= '{left_value: lv, right_value: rv};
                if (al > dl_reg) dl_reg <= al;
                if (ar > dr_reg) dr_reg <= ar;
                if (al > ll_reg) ll_reg <= al;
                if (ar > lr_reg) lr_reg <= ar;
            end else if (accept && s_data.mode != MODE_AUDIO) begin
                case (s_data.mode)
                    MODE_DIAG: begin
                        m_data_reg <= '{left_value: {1'b0, dl_reg},
                                        right_value: {1'b0, dr_reg}};
                        dl_reg <= '0; dr_reg <= '0;
                    end
                    MODE_LED: begin
                        m_data_reg <= '{left_value: {1'b0, ll_reg},
                                        right_value: {1'b0, lr_reg}};
                        ll_reg <= '0; lr_reg <= '0;
                    end
                    default: m_data_reg <= '0;
                endcase
            end
        end
    end
endmodule
`default_nettype wire
